FILE: sv/block_bitmap_allocator_unit_defines.svh
// assertion macros for the block bitmap allocator
`ifndef BLOCK_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH
`define BLOCK_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef SYNTH
`define BBA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BBA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BBA_ASSERT(lbl, prop, msg)
`define BBA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: sv/bba_pkg.sv
package bba_pkg;

    localparam int NUM_BLOCKS_DEF = 4096;
    localparam int WORD_BITS_DEF  = 32;
    localparam int IDX_W          = 12;
    localparam int INDEX_SPAN     = 4096;

    typedef enum logic [1:0] {
        OP_FIND  = 2'd0,
        OP_SET   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_TEST  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'd0,
        ST_IDLE  = 3'd1,
        ST_DIV   = 3'd2,
        ST_RD    = 3'd3,
        ST_MOD   = 3'd4,
        ST_SCAN  = 3'd5,
        ST_ENC   = 3'd6
    } state_t;

endpackage

FILE: sv/bba_ram.sv
module bba_ram #(
    parameter int WIDTH = bba_pkg::WORD_BITS_DEF,
    parameter int DEPTH = bba_pkg::NUM_BLOCKS_DEF / bba_pkg::WORD_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                        wdata,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/bba_lowbit.sv
module bba_lowbit #(
    parameter int WORD_BITS = bba_pkg::WORD_BITS_DEF
) (
    input  logic [WORD_BITS-1:0]         free_bits,
    output logic [$clog2(WORD_BITS)-1:0] pos
);

    localparam int BW = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] low_bit;

    // isolate the lowest set bit
    assign low_bit = free_bits & (~free_bits + WORD_BITS'(1));

    // one-hot to binary
    for (genvar k = 0; k < BW; k++)
    begin : g_pos
        logic [WORD_BITS-1:0] sel;
        for (genvar i = 0; i < WORD_BITS; i++)
        begin : g_sel
            assign sel[i] = low_bit[i] & ((i >> k) % 2 == 1);
        end
        assign pos[k] = |sel;
    end

endmodule

FILE: sv/block_bitmap_allocator_unit.sv
// channel   | ports                           | handshake
// ----------+---------------------------------+-------------------------------
// request   | op, block_index                 | taken when start && !busy
// result    | result_block, found, used       | done high for one cycle
//
// set, clear and test go from start to done through divide, read and modify;
// set and clear write back through the single port of the bitmap memory
// find reads one bitmap word per cycle from the lowest word up, at most
// ceil(min(NUM_BLOCKS, 4096) / WORD_BITS) words, up to and including the
// first word that holds a free block
// after reset a clearing pass writes every memory word, one a cycle, with busy
// high until the pass ends
// the receiver cannot stall; a new request may start in the cycle of done
module block_bitmap_allocator_unit #(
    parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF,
    parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                op,
    input  logic [bba_pkg::IDX_W-1:0] block_index,
    output logic                      done,
    output logic [bba_pkg::IDX_W-1:0] result_block,
    output logic                      found,
    output logic                      used
);

`include "block_bitmap_allocator_unit_defines.svh"

    localparam int IDX_W      = bba_pkg::IDX_W;
    localparam int MAP_WORDS  = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW         = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;
    localparam int BW         = $clog2(WORD_BITS);
    localparam int SCAN_LIMIT = NUM_BLOCKS < bba_pkg::INDEX_SPAN ?
                                NUM_BLOCKS : bba_pkg::INDEX_SPAN;
    localparam int SCAN_WORDS = (SCAN_LIMIT + WORD_BITS - 1) / WORD_BITS;
    localparam int LAST_BITS  = SCAN_LIMIT - (SCAN_WORDS - 1) * WORD_BITS;
    localparam int DIV_SH     = IDX_W + BW;
    localparam int DIV_M      = (1 << DIV_SH) / WORD_BITS + 1;
    localparam int PW         = IDX_W + DIV_SH;

    localparam logic [WORD_BITS-1:0] ALL_ONES  = {WORD_BITS{1'b1}};
    localparam logic [WORD_BITS-1:0] LAST_MASK = ALL_ONES >> (WORD_BITS - LAST_BITS);
    localparam logic [AW-1:0]        LAST_W    = AW'(SCAN_WORDS - 1);
    localparam logic [AW-1:0]        END_W     = AW'(MAP_WORDS - 1);

    bba_pkg::state_t state_reg, state_next;
    bba_pkg::op_t    op_reg, op_next;

    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 in_range_reg, in_range_next;
    logic [IDX_W-1:0]     q_reg, q_next;
    logic [BW-1:0]        bit_reg, bit_next;
    logic [AW-1:0]        ptr_reg, ptr_next;
    logic                 rd_done_reg, rd_done_next;
    logic                 chk_vld_reg, chk_vld_next;
    logic                 chk_last_reg, chk_last_next;
    logic [IDX_W-1:0]     base_reg, base_next;
    logic [WORD_BITS-1:0] free_reg, free_next;
    logic                 done_reg, done_next;
    logic [IDX_W-1:0]     result_reg, result_next;
    logic                 found_reg, found_next;
    logic                 used_reg, used_next;

    logic                 mem_we;
    logic [AW-1:0]        mem_addr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [WORD_BITS-1:0] mem_rdata;
    logic [WORD_BITS-1:0] scan_free;
    logic [WORD_BITS-1:0] bit_mask;
    logic [PW-1:0]        div_prod;
    logic [IDX_W-1:0]     q_times_w;
    logic [IDX_W-1:0]     rem;
    logic [BW-1:0]        enc_pos;
    logic                 accept;

    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    bba_lowbit #(
        .WORD_BITS (WORD_BITS)
    ) u_lowbit (
        .free_bits (free_reg),
        .pos       (enc_pos)
    );

    assign accept    = start && (state_reg == bba_pkg::ST_IDLE);
    assign scan_free = ~mem_rdata & (chk_last_reg ? LAST_MASK : ALL_ONES);
    assign bit_mask  = WORD_BITS'(1) << bit_reg;
    // word index by reciprocal multiply, exact for 12-bit indexes
    assign div_prod  = PW'(idx_reg) * PW'(DIV_M);
    assign q_times_w = IDX_W'(q_reg * WORD_BITS);
    assign rem       = idx_reg - q_times_w;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bba_pkg::ST_CLEAR:
            begin
                if (ptr_reg == END_W)
                begin
                    state_next = bba_pkg::ST_IDLE;
                end
            end
            bba_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (bba_pkg::op_t'(op) == bba_pkg::OP_FIND) ?
                                 bba_pkg::ST_SCAN : bba_pkg::ST_DIV;
                end
            end
            bba_pkg::ST_DIV:  state_next = bba_pkg::ST_RD;
            bba_pkg::ST_RD:   state_next = bba_pkg::ST_MOD;
            bba_pkg::ST_MOD:  state_next = bba_pkg::ST_IDLE;
            bba_pkg::ST_SCAN:
            begin
                if (chk_vld_reg)
                begin
                    if (scan_free != '0)
                    begin
                        state_next = bba_pkg::ST_ENC;
                    end
                    else if (chk_last_reg)
                    begin
                        state_next = bba_pkg::ST_IDLE;
                    end
                end
            end
            bba_pkg::ST_ENC:  state_next = bba_pkg::ST_IDLE;
            default:          state_next = bba_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        op_next       = op_reg;
        idx_next      = idx_reg;
        in_range_next = in_range_reg;
        q_next        = q_reg;
        bit_next      = bit_reg;
        ptr_next      = ptr_reg;
        rd_done_next  = rd_done_reg;
        chk_vld_next  = 1'b0;
        chk_last_next = 1'b0;
        base_next     = base_reg;
        free_next     = free_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        found_next    = found_reg;
        used_next     = used_reg;
        mem_we        = 1'b0;
        mem_addr      = AW'(q_reg);
        mem_wdata     = '0;
        unique case (state_reg)
            bba_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = ptr_reg;
                mem_wdata = '0;
                ptr_next  = ptr_reg + AW'(1);
            end
            bba_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    op_next       = bba_pkg::op_t'(op);
                    idx_next      = block_index;
                    in_range_next = 32'(block_index) < 32'(NUM_BLOCKS);
                    ptr_next      = '0;
                    rd_done_next  = 1'b0;
                    base_next     = '0;
                end
            end
            bba_pkg::ST_DIV:
            begin
                q_next = div_prod[PW-1:DIV_SH];
            end
            bba_pkg::ST_RD:
            begin
                bit_next = rem[BW-1:0];
            end
            bba_pkg::ST_MOD:
            begin
                mem_we      = in_range_reg && (op_reg == bba_pkg::OP_SET ||
                                               op_reg == bba_pkg::OP_CLEAR);
                mem_wdata   = (op_reg == bba_pkg::OP_SET) ? (mem_rdata | bit_mask) :
                                                            (mem_rdata & ~bit_mask);
                done_next   = 1'b1;
                result_next = idx_reg;
                found_next  = 1'b1;
                used_next   = in_range_reg && (op_reg == bba_pkg::OP_TEST) &&
                              ((mem_rdata & bit_mask) != '0);
            end
            bba_pkg::ST_SCAN:
            begin
                mem_addr = ptr_reg;
                if (!rd_done_reg)
                begin
                    chk_vld_next  = 1'b1;
                    chk_last_next = (ptr_reg == LAST_W);
                    rd_done_next  = (ptr_reg == LAST_W);
                    ptr_next      = ptr_reg + AW'(1);
                end
                if (chk_vld_reg)
                begin
                    if (scan_free != '0)
                    begin
                        free_next = scan_free;
                    end
                    else if (chk_last_reg)
                    begin
                        done_next   = 1'b1;
                        result_next = '0;
                        found_next  = 1'b0;
                        used_next   = 1'b0;
                    end
                    else
                    begin
                        base_next = base_reg + IDX_W'(WORD_BITS);
                    end
                end
            end
            bba_pkg::ST_ENC:
            begin
                done_next   = 1'b1;
                result_next = base_reg + IDX_W'(enc_pos);
                found_next  = 1'b1;
                used_next   = 1'b0;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bba_pkg::ST_CLEAR;
            ptr_reg      <= '0;
            rd_done_reg  <= 1'b0;
            chk_vld_reg  <= 1'b0;
            chk_last_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ptr_reg      <= ptr_next;
            rd_done_reg  <= rd_done_next;
            chk_vld_reg  <= chk_vld_next;
            chk_last_reg <= chk_last_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        idx_reg      <= idx_next;
        in_range_reg <= in_range_next;
        q_reg        <= q_next;
        bit_reg      <= bit_next;
        base_reg     <= base_next;
        free_reg     <= free_next;
        result_reg   <= result_next;
        found_reg    <= found_next;
        used_reg     <= used_next;
    end

    assign busy         = (state_reg != bba_pkg::ST_IDLE);
    assign done         = done_reg;
    assign result_block = result_reg;
    assign found        = found_reg;
    assign used         = used_reg;

    `BBA_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted request did not set busy")
    `BBA_ASSERT(a_single_done, done |=> !done, "result strobe longer than one cycle")
    `BBA_ASSERT(a_empty_find, (done && !found) |-> (result_block == '0 && !used), "bad full-disk result")
    `BBA_ASSERT(a_used_test, (done && used) |-> (op_reg == bba_pkg::OP_TEST), "used outside test")
    `BBA_ASSERT_ALWAYS(a_write_state, mem_we |-> (state_reg == bba_pkg::ST_CLEAR || state_reg == bba_pkg::ST_MOD), "bitmap written outside clear or modify")

endmodule
